[hdl/sxpd_pkg.sv]
// Shared types and constants for the sync-word XOR packet deframer.
`timescale 1ns / 1ps

package sxpd_pkg;

	localparam int PACKET_BYTES_DEF = 14;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NO_LINE     = 2'd2;

	localparam logic [7:0]  SYNC_FIRST_RST  = 8'hAA;
	localparam logic [7:0]  SYNC_SECOND_RST = 8'h55;
	localparam logic [15:0] NO_LINE_RST     = 16'd250;

	localparam int FLAG_OBSTACLE_BIT = 0;
	localparam int FLAG_WALL_BIT     = 1;
	localparam int FLAG_COLOR_LSB    = 2;

	typedef struct packed {
		logic at_check;   // next byte is the checksum
		logic good;       // checksum byte taken and it matches
	} frame_stat_t;

endpackage

[hdl/sxpd_frame.sv]
// Sync hunt, payload capture and running XOR for one packet.
`timescale 1ns / 1ps

module sxpd_frame
	import sxpd_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	localparam int PAYLOAD_BYTES = PACKET_BYTES - 3
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic [7:0]                    rx_byte,
	input  logic [7:0]                    sync_first,
	input  logic [7:0]                    sync_second,
	output logic [PAYLOAD_BYTES-1:0][7:0] payload,
	output frame_stat_t                   stat
);

	localparam int POS_W = $clog2(PACKET_BYTES);
	localparam logic [POS_W-1:0] POS_HUNT  = POS_W'(0);
	localparam logic [POS_W-1:0] POS_SYNC1 = POS_W'(1);
	localparam logic [POS_W-1:0] POS_DATA0 = POS_W'(2);
	localparam logic [POS_W-1:0] POS_CHECK = POS_W'(PACKET_BYTES - 1);

	logic [POS_W-1:0]              pos_q;
	logic [7:0]                    xor_q;
	logic [PAYLOAD_BYTES-1:0][7:0] store_q;
	logic [POS_W-1:0]              wr_idx;
	logic                          in_data;

	assign in_data = (pos_q >= POS_DATA0) && (pos_q < POS_CHECK);
	assign wr_idx  = pos_q - POS_DATA0;

	assign stat.at_check = (pos_q == POS_CHECK);
	assign stat.good     = step && (pos_q == POS_CHECK) && (rx_byte == xor_q);
	assign payload       = store_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HUNT;
			xor_q <= 8'd0;
		end else if (step) begin
			priority if (pos_q == POS_SYNC1) begin
				if (rx_byte == sync_second) begin
					pos_q <= POS_DATA0;
					xor_q <= 8'd0;
				end else if (rx_byte != sync_first) begin
					pos_q <= POS_HUNT;
				end
			end else if (in_data) begin
				xor_q <= xor_q ^ rx_byte;
				pos_q <= pos_q + POS_W'(1);
			end else if (pos_q == POS_CHECK) begin
				pos_q <= POS_HUNT;
			end else begin
				pos_q <= (rx_byte == sync_first) ? POS_SYNC1 : POS_HUNT;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < PAYLOAD_BYTES; i++) begin
			if (step && in_data && (wr_idx == POS_W'(i))) begin
				store_q[i] <= rx_byte;
			end
		end
	end

endmodule

[hdl/sync_xor_packet_deframer.sv]
// Top level of the sync-word framed packet receiver with XOR checksum.
// Latency: a result is presented in the cycle after its checksum byte is accepted.
// Throughput: one byte per cycle; in_ready drops only while the checksum byte is
//   due and the previous result is still held in the output register with out_ready low.
// Reset: configuration returns to its defaults, the receiver hunts for sync and
//   no result is pending; the payload bytes are undefined until received.
`timescale 1ns / 1ps

module sync_xor_packet_deframer
	import sxpd_pkg::*;
#(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [15:0]           obstacle_x,
	output logic [15:0]           obstacle_y,
	output logic [15:0]           wall_x,
	output logic [15:0]           wall_y,
	output logic [15:0]           line_bottom_y,
	output logic [7:0]            flag_byte,
	output logic                  obstacle_seen,
	output logic                  wall_seen,
	output logic [1:0]            obstacle_color,
	output logic                  line_seen
);

	localparam int PAYLOAD_BYTES = PACKET_BYTES - 3;

	logic [7:0]                    sync_first_q;
	logic [7:0]                    sync_second_q;
	logic [15:0]                   no_line_q;
	logic [PAYLOAD_BYTES-1:0][7:0] payload;
	frame_stat_t                   stat;
	logic                          step;
	logic                          out_valid_q;
	logic [15:0]                   bottom;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_first_q  <= SYNC_FIRST_RST;
			sync_second_q <= SYNC_SECOND_RST;
			no_line_q     <= NO_LINE_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SYNC_FIRST:  sync_first_q  <= cfg_wdata[7:0];
				REG_SYNC_SECOND: sync_second_q <= cfg_wdata[7:0];
				REG_NO_LINE:     no_line_q     <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !out_valid_q || out_ready || !stat.at_check;
	assign step     = in_valid && in_ready;

	sxpd_frame #(
		.PACKET_BYTES(PACKET_BYTES)
	) u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.rx_byte    (rx_byte),
		.sync_first (sync_first_q),
		.sync_second(sync_second_q),
		.payload    (payload),
		.stat       (stat)
	);

	assign bottom = {payload[8], payload[9]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.good) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.good) begin
			obstacle_x     <= {payload[0], payload[1]};
			obstacle_y     <= {payload[2], payload[3]};
			wall_x         <= {payload[4], payload[5]};
			wall_y         <= {payload[6], payload[7]};
			line_bottom_y  <= bottom;
			flag_byte      <= payload[10];
			obstacle_seen  <= payload[10][FLAG_OBSTACLE_BIT];
			wall_seen      <= payload[10][FLAG_WALL_BIT];
			obstacle_color <= payload[10][FLAG_COLOR_LSB +: 2];
			line_seen      <= (bottom != no_line_q);
		end
	end

	assign out_valid = out_valid_q;

endmodule

[hdl/sxpd_checker.sv]
// Port-level assertions for the deframer, bound to the top level.
`timescale 1ns / 1ps

module sxpd_checker
	import sxpd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  cfg_we,
	input logic [CFG_IDX_W-1:0]  cfg_idx,
	input logic [CFG_DATA_W-1:0] cfg_wdata,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [15:0]           obstacle_x,
	input logic [15:0]           line_bottom_y,
	input logic [7:0]            flag_byte,
	input logic                  obstacle_seen,
	input logic                  wall_seen,
	input logic [1:0]            obstacle_color,
	input logic                  line_seen
);

	logic [15:0] no_line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			no_line_q <= NO_LINE_RST;
		end else if (cfg_we && (cfg_idx == REG_NO_LINE)) begin
			no_line_q <= cfg_wdata;
		end
	end

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(obstacle_x) && $stable(flag_byte))
		else $error("result changed while stalled");

	// only a stalled output can hold off input
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled without output backpressure");

	// a new result follows an accepted byte
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without an accepted byte");

	a_flag_decode: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> obstacle_seen == flag_byte[FLAG_OBSTACLE_BIT]
			&& wall_seen == flag_byte[FLAG_WALL_BIT]
			&& obstacle_color == flag_byte[FLAG_COLOR_LSB +: 2])
		else $error("flag decode mismatch");

	a_line_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_seen == (line_bottom_y != no_line_q))
		else $error("line flag does not match sentinel");

endmodule

bind sync_xor_packet_deframer sxpd_checker u_sxpd_checker (.*);

[tb/sv/tb_top.sv]
// Self-checking testbench for the sync-word XOR packet deframer.
`timescale 1ns / 1ps

module tb_top;
	import sxpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int PAYLOAD_LEN   = PACKET_BYTES_DEF - 3;
	localparam logic [3:0] POS_HUNT    = 4'd0;
	localparam logic [3:0] POS_SYNC2   = 4'd1;
	localparam logic [3:0] POS_PAYLOAD = 4'd2;
	localparam logic [3:0] POS_CHECK   = 4'(PACKET_BYTES_DEF - 1);
	localparam int SETTLE_CYCLES = 4;

	typedef logic [7:0] payload_t [0:PAYLOAD_LEN-1];

	typedef struct packed {
		logic [15:0] obstacle_x;
		logic [15:0] obstacle_y;
		logic [15:0] wall_x;
		logic [15:0] wall_y;
		logic [15:0] line_bottom_y;
		logic [7:0]  flag_byte;
		logic        obstacle_seen;
		logic        wall_seen;
		logic [1:0]  obstacle_color;
		logic        line_seen;
	} frame_fields_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [7:0]            rx_byte = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [15:0]           obstacle_x;
	logic [15:0]           obstacle_y;
	logic [15:0]           wall_x;
	logic [15:0]           wall_y;
	logic [15:0]           line_bottom_y;
	logic [7:0]            flag_byte;
	logic                  obstacle_seen;
	logic                  wall_seen;
	logic [1:0]            obstacle_color;
	logic                  line_seen;

	// predictor state and its copy of the registers
	logic [7:0]  cur_sync_first  = SYNC_FIRST_RST;
	logic [7:0]  cur_sync_second = SYNC_SECOND_RST;
	logic [15:0] cur_no_line     = NO_LINE_RST;
	logic [3:0]  frame_pos = POS_HUNT;
	logic [7:0]  frame_sum = '0;
	payload_t    frame_bytes;

	frame_fields_t expected_frames[$];
	int errors = 0;
	int bytes_sent = 0;
	int src_idle_pct = 14;
	int dst_idle_pct = 64;

	sync_xor_packet_deframer u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.obstacle_x(obstacle_x), .obstacle_y(obstacle_y),
		.wall_x(wall_x), .wall_y(wall_y), .line_bottom_y(line_bottom_y),
		.flag_byte(flag_byte), .obstacle_seen(obstacle_seen), .wall_seen(wall_seen),
		.obstacle_color(obstacle_color), .line_seen(line_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= dst_idle_pct);
	end

	// advance the predicted receiver by one accepted byte
	task automatic track_byte(input logic [7:0] b);
		frame_fields_t r;
		case (frame_pos)
			POS_SYNC2: begin
				if (b == cur_sync_second) begin
					frame_pos = POS_PAYLOAD;
					frame_sum = '0;
				end else if (b != cur_sync_first) begin
					frame_pos = POS_HUNT;
				end
			end
			POS_CHECK: begin
				frame_pos = POS_HUNT;
				if (b == frame_sum) begin
					r.obstacle_x     = {frame_bytes[0], frame_bytes[1]};
					r.obstacle_y     = {frame_bytes[2], frame_bytes[3]};
					r.wall_x         = {frame_bytes[4], frame_bytes[5]};
					r.wall_y         = {frame_bytes[6], frame_bytes[7]};
					r.line_bottom_y  = {frame_bytes[8], frame_bytes[9]};
					r.flag_byte      = frame_bytes[10];
					r.obstacle_seen  = r.flag_byte[FLAG_OBSTACLE_BIT];
					r.wall_seen      = r.flag_byte[FLAG_WALL_BIT];
					r.obstacle_color = r.flag_byte[FLAG_COLOR_LSB +: 2];
					r.line_seen      = (r.line_bottom_y != cur_no_line);
					expected_frames.push_back(r);
				end
			end
			default: begin
				if (frame_pos >= POS_PAYLOAD && frame_pos < POS_CHECK) begin
					frame_bytes[frame_pos - POS_PAYLOAD] = b;
					frame_sum = frame_sum ^ b;
					frame_pos = frame_pos + 4'd1;
				end else begin
					frame_pos = (b == cur_sync_first) ? POS_SYNC2 : POS_HUNT;
				end
			end
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_ready !== 1'b1);
		track_byte(b);
		bytes_sent++;
	endtask

	function automatic logic [7:0] payload_xor(input payload_t p);
		logic [7:0] s;
		s = '0;
		for (int k = 0; k < PAYLOAD_LEN; k++) s = s ^ p[k];
		return s;
	endfunction

	task automatic send_packet(input payload_t p, input bit sum_ok, input bit dup_lead);
		logic [7:0] s;
		s = payload_xor(p);
		send_byte(cur_sync_first);
		if (dup_lead) send_byte(cur_sync_first);
		send_byte(cur_sync_second);
		for (int k = 0; k < PAYLOAD_LEN; k++) send_byte(p[k]);
		send_byte(sum_ok ? s : s ^ 8'($urandom_range(1, 255)));
	endtask

	function automatic payload_t random_payload();
		payload_t p;
		for (int k = 0; k < PAYLOAD_LEN; k++) p[k] = 8'($urandom_range(255));
		if ($urandom_range(3) == 0) {p[8], p[9]} = cur_no_line;
		if ($urandom_range(3) == 0) p[$urandom_range(PAYLOAD_LEN - 1)] = cur_sync_first;
		if ($urandom_range(3) == 0) p[$urandom_range(PAYLOAD_LEN - 1)] = cur_sync_second;
		return p;
	endfunction

	// let every pending result drain, then allow the pipeline to settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_frames.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SYNC_FIRST:  cur_sync_first  = val[7:0];
			REG_SYNC_SECOND: cur_sync_second = val[7:0];
			REG_NO_LINE:     cur_no_line     = val;
			default: ;
		endcase
	endtask

	function automatic void field_cmp(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %h got %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		frame_fields_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction, expected none got %h/%h/%h/%h/%h/%h",
					$time, obstacle_x, obstacle_y, wall_x, wall_y, line_bottom_y, flag_byte);
			end else begin
				want = expected_frames.pop_front();
				field_cmp("obstacle_x", want.obstacle_x, obstacle_x);
				field_cmp("obstacle_y", want.obstacle_y, obstacle_y);
				field_cmp("wall_x", want.wall_x, wall_x);
				field_cmp("wall_y", want.wall_y, wall_y);
				field_cmp("line_bottom_y", want.line_bottom_y, line_bottom_y);
				field_cmp("flag_byte", 16'(want.flag_byte), 16'(flag_byte));
				field_cmp("obstacle_seen", 16'(want.obstacle_seen), 16'(obstacle_seen));
				field_cmp("wall_seen", 16'(want.wall_seen), 16'(wall_seen));
				field_cmp("obstacle_color", 16'(want.obstacle_color), 16'(obstacle_color));
				field_cmp("line_seen", 16'(want.line_seen), 16'(line_seen));
			end
		end
	end

	task automatic test_full_scale_frame();
		payload_t p;
		for (int k = 0; k < PAYLOAD_LEN; k++) p[k] = 8'hFF;
		send_packet(p, 1'b1, 1'b0);
	endtask

	task automatic test_checksum_reject();
		payload_t p;
		for (int k = 0; k < PAYLOAD_LEN; k++) p[k] = 8'h00;
		send_byte(8'h00);
		send_packet(p, 1'b0, 1'b0);
	endtask

	// broken sync pair, repeated first sync, sync bytes as data, bottom at sentinel
	task automatic test_sync_restart();
		payload_t p;
		p = random_payload();
		p[0] = cur_sync_first;
		p[1] = cur_sync_second;
		{p[8], p[9]} = cur_no_line;
		p[10] = 8'h0F;
		send_byte(cur_sync_first);
		send_byte(8'h00);
		send_packet(p, 1'b1, 1'b1);
	endtask

	task automatic test_equal_sync_bytes();
		payload_t p;
		wait_idle();
		write_reg(REG_SYNC_FIRST, 16'hFF00);
		write_reg(REG_SYNC_SECOND, 16'h0000);
		write_reg(REG_NO_LINE, 16'hFFFF);
		p = random_payload();
		{p[8], p[9]} = 16'hFFFF;
		p[10] = 8'hF0;
		send_packet(p, 1'b1, 1'b0);
	endtask

	task automatic test_unused_register();
		payload_t p;
		wait_idle();
		write_reg(REG_UNUSED, 16'h1234);
		write_reg(REG_SYNC_FIRST, 16'(SYNC_FIRST_RST));
		write_reg(REG_SYNC_SECOND, 16'(SYNC_SECOND_RST));
		write_reg(REG_NO_LINE, 16'h0000);
		p = random_payload();
		send_packet(p, 1'b1, 1'b0);
	endtask

	task automatic test_random_stream(input int n_items);
		int target;
		int pick;
		target = bytes_sent + n_items;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 72) begin
				send_packet(random_payload(), $urandom_range(99) < 85, $urandom_range(9) == 0);
			end else if (pick < 86) begin
				send_byte(8'($urandom_range(255)));
			end else if (pick < 95) begin
				send_byte(cur_sync_first);
				send_byte(8'($urandom_range(255)));
			end else begin
				send_byte(cur_sync_second);
			end
		end
	endtask

	task automatic random_config(input logic [7:0] first_sync);
		logic [7:0] second_sync;
		second_sync = ($urandom_range(7) == 0) ? first_sync : 8'($urandom_range(255));
		wait_idle();
		write_reg(REG_SYNC_FIRST, {8'($urandom_range(255)), first_sync});
		write_reg(REG_SYNC_SECOND, {8'($urandom_range(255)), second_sync});
		write_reg(REG_NO_LINE, 16'($urandom_range(65535)));
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_full_scale_frame();
		test_checksum_reject();
		test_sync_restart();
		test_equal_sync_bytes();
		test_unused_register();

		random_config(8'($urandom_range(255)));
		test_random_stream(460);

		src_idle_pct = 64;
		dst_idle_pct = 14;
		random_config(8'hFF);
		test_random_stream(230);
		wait_idle();
		test_random_stream(230);

		src_idle_pct = 0;
		dst_idle_pct = 0;
		wait_idle();
		write_reg(REG_SYNC_FIRST, 16'(SYNC_FIRST_RST));
		write_reg(REG_SYNC_SECOND, 16'(SYNC_SECOND_RST));
		write_reg(REG_NO_LINE, 16'(NO_LINE_RST));
		test_random_stream(480);

		wait_idle();
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
hdl/sxpd_pkg.sv
hdl/sxpd_frame.sv
hdl/sync_xor_packet_deframer.sv
hdl/sxpd_checker.sv
tb/sv/tb_top.sv
